>>> sv/b64d_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// b64d_pkg
// Shared types, constants and the character decode function of the base64
// stream decoder.
// ============================================================================
package b64d_pkg;

    localparam int LENGTH_WIDTH_DEFAULT = 16;
    localparam int CFG_WIDTH            = 16;
    localparam int LENGTH_RESET         = 20;

    localparam logic [7:0] PAD_CHAR    = 8'h3d;
    localparam logic [7:0] PLUS_CHAR   = 8'h2b;
    localparam logic [7:0] SLASH_CHAR  = 8'h2f;
    localparam logic [5:0] PLUS_SEXTET = 6'h3e;
    localparam logic [5:0] SLASH_SEXTET = 6'h3f;
    localparam logic [7:0] HIGH_PAIR_MASK = 8'hc0;

    // One input word as held in the input register.
    typedef struct packed {
        logic [7:0] symbol;
        logic       frame_start;
    } in_item_t;

    // One decoded group handed from the decode core to the output serializer.
    typedef struct packed {
        logic [2:0][7:0] bytes;   // bytes[0] leaves first
        logic [1:0]      count;   // number of bytes to emit, 1 to 3
        logic            fin;     // the last byte of this group ends the frame
        logic            status;  // error flag reported with the final byte
    } group_t;

    // Result of the character lookup: an invalid flag and the sextet value.
    typedef struct packed {
        logic       bad;
        logic [5:0] sextet;
    } sextet_t;

    // Maps one character to its sextet. Padding decodes as zero; anything
    // outside the alphabet is flagged and also decodes as zero.
    function automatic sextet_t sextet_of(input logic [7:0] c);
        sextet_t r;
        r.bad    = 1'b0;
        r.sextet = 6'd0;
        if (c >= 8'h41 && c <= 8'h5a) begin
            r.sextet = 6'(c - 8'h41);
        end else if (c >= 8'h61 && c <= 8'h7a) begin
            r.sextet = 6'(c - 8'h61 + 8'd26);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            r.sextet = 6'(c - 8'h30 + 8'd52);
        end else if (c == PLUS_CHAR) begin
            r.sextet = PLUS_SEXTET;
        end else if (c == SLASH_CHAR) begin
            r.sextet = SLASH_SEXTET;
        end else if (c == PAD_CHAR) begin
            r.sextet = 6'd0;
        end else begin
            r.bad = 1'b1;
        end
        return r;
    endfunction

endpackage

>>> sv/base64_stream_decoder_top.sv
`timescale 1ns / 1ps
// ============================================================================
// base64_stream_decoder_top
// Streaming base64 decoder: one character word in, decoded byte words out.
// ============================================================================
//
//  Channel  Dir  Payload                                  Handshake
//  -------  ---  ---------------------------------------  ----------------
//  s_       in   tdata: symbol[7:0]; tuser: frame_start   tvalid / tready
//  m_       out  tdata: data_byte[7:0]; tlast: last;      tvalid / tready
//                tuser: status
//  cfg_     in   cfg_wdata: decoded_length                cfg_we, no wait
//
// The decoder takes one character word per cycle while the output is taken. A
// word waits in the input register and is decoded against the frame state
// there; every fourth character of a group loads up to three bytes into the
// output serializer at the next edge, which sends one byte per cycle while
// m_tready is high. The serializer's single drain port sets the throughput:
// three bytes per four characters keeps it below one word per cycle, so the
// input runs at full rate while the output is taken.
// The serializer register offers a group's first byte once it is loaded.
// Reset is synchronous and active low; it empties both registers, clears the
// frame state and sets decoded_length to 20. A stalled output holds the
// current group; the input register then fills and s_tready drops.
//
// The frame start flag restarts the frame with the current decoded_length.
// Characters outside the alphabet decode as zero and set the error status;
// '=' decodes as zero, and is required in the unused places of the final
// group. The status bit on tuser is only ever set together with tlast.
//
module base64_stream_decoder_top #(
    parameter int LENGTH_WIDTH = b64d_pkg::LENGTH_WIDTH_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Configuration: decoded_length, written when cfg_we is high.
    input  logic                            cfg_we,
    input  logic [b64d_pkg::CFG_WIDTH-1:0]  cfg_wdata,
    // Character words.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [7:0] symbol
    input  logic                            s_tuser,   // [0] frame_start
    // Decoded byte words.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [7:0]                      m_tdata,   // [7:0] data_byte
    output logic                            m_tlast,   // last byte of the frame
    output logic                            m_tuser    // [0] status
);
    import b64d_pkg::*;

    in_item_t s_item;
    in_item_t held_item;
    logic     held_valid;
    logic     advance;
    logic     grp_load;
    logic     can_load;
    group_t   grp;

    assign s_item.symbol      = s_tdata;
    assign s_item.frame_start = s_tuser;

    b64d_in_reg u_in_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .item_i    (s_item),
        .advance_i (advance),
        .valid_o   (held_valid),
        .item_o    (held_item)
    );

    b64d_core #(
        .LENGTH_WIDTH (LENGTH_WIDTH)
    ) u_core (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .in_valid_i     (held_valid),
        .in_item_i      (held_item),
        .out_can_load_i (can_load),
        .advance_o      (advance),
        .grp_load_o     (grp_load),
        .grp_o          (grp)
    );

    b64d_out_ser u_out_ser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load_i     (grp_load),
        .grp_i      (grp),
        .can_load_o (can_load),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

    // The error status is only reported on the final byte of a frame.
    a_status_with_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("status set on a byte that does not end the frame");

    // Reset leaves no byte pending on the output.
    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output word pending right after reset");

    // An empty input register never refuses a word.
    a_empty_accepts: assert property (@(posedge aclk) disable iff (!aresetn)
        !held_valid |-> s_tready)
        else $error("input stalled while the input register is empty");

    // A group is only loaded when the decode core takes the held word.
    a_load_needs_word: assert property (@(posedge aclk) disable iff (!aresetn)
        grp_load |-> held_valid && can_load)
        else $error("group loaded without a held word or room in the output");

endmodule

>>> sv/b64d_in_reg.sv
`timescale 1ns / 1ps
// ============================================================================
// b64d_in_reg
// Input register: holds one character word until the decode core takes it.
// ============================================================================
module b64d_in_reg (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  b64d_pkg::in_item_t  item_i,
    input  logic                advance_i,
    output logic                valid_o,
    output b64d_pkg::in_item_t  item_o
);
    import b64d_pkg::*;

    logic     valid_reg, valid_next;
    in_item_t item_reg, item_next;

    // A new word may enter when the register is empty or is drained now.
    assign s_tready = !valid_reg || advance_i;

    always_comb begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
            item_next  = item_i;
        end else if (advance_i) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        item_reg <= item_next;
    end

    assign valid_o = valid_reg;
    assign item_o  = item_reg;

endmodule

>>> sv/b64d_core.sv
`timescale 1ns / 1ps
// ============================================================================
// b64d_core
// Decode core: frame and group state, length register and group assembly.
// ============================================================================
module b64d_core #(
    parameter int LENGTH_WIDTH = b64d_pkg::LENGTH_WIDTH_DEFAULT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [b64d_pkg::CFG_WIDTH-1:0]   cfg_wdata,
    input  logic                             in_valid_i,
    input  b64d_pkg::in_item_t               in_item_i,
    input  logic                             out_can_load_i,
    output logic                             advance_o,
    output logic                             grp_load_o,
    output b64d_pkg::group_t                 grp_o
);
    import b64d_pkg::*;

    logic [LENGTH_WIDTH-1:0] len_reg, len_next;
    logic [LENGTH_WIDTH-1:0] owed_reg, owed_next;
    logic [17:0]             held_reg, held_next;
    logic [1:0]              pos_reg, pos_next;
    logic                    err_reg, err_next;

    logic [LENGTH_WIDTH-1:0] owed_eff;
    logic [17:0]             held_eff;
    logic [1:0]              pos_eff;
    logic                    err_eff;
    logic                    is_pad;
    logic                    emit;
    sextet_t                 sx;
    logic [5:0]              s0, s1, s2;
    logic [1:0]              n;

    always_comb begin
        len_next = len_reg;
        if (cfg_we) begin
            len_next = LENGTH_WIDTH'(32'(cfg_wdata));
        end
    end

    always_comb begin
        // A frame start clears the frame state before this character counts.
        owed_eff = in_item_i.frame_start ? len_reg : owed_reg;
        held_eff = in_item_i.frame_start ? 18'd0 : held_reg;
        pos_eff  = in_item_i.frame_start ? 2'd0 : pos_reg;
        err_eff  = in_item_i.frame_start ? 1'b0 : err_reg;

        is_pad = (in_item_i.symbol == PAD_CHAR);
        sx     = sextet_of(in_item_i.symbol);
        emit   = (owed_eff != '0) && (pos_eff == 2'd3);

        s0 = held_eff[17:12];
        s1 = held_eff[11:6];
        s2 = held_eff[5:0];
        n  = (owed_eff < LENGTH_WIDTH'(3)) ? owed_eff[1:0] : 2'd3;

        owed_next = owed_eff;
        held_next = held_eff;
        pos_next  = pos_eff;
        err_next  = err_eff;

        grp_o.bytes[0] = {s0, s1[5:4]};
        grp_o.bytes[1] = {s1[3:0], s2[5:2]};
        grp_o.bytes[2] = ({s2[1:0], 6'd0} & HIGH_PAIR_MASK) | {2'b00, sx.sextet};
        grp_o.count    = n;
        grp_o.fin      = (owed_eff <= LENGTH_WIDTH'(3));
        grp_o.status   = 1'b0;

        if (owed_eff != '0) begin
            err_next = err_eff | sx.bad;
            if (pos_eff != 2'd3) begin
                // The third character must be padding when only one byte is owed.
                if (pos_eff == 2'd2 && owed_eff == LENGTH_WIDTH'(1) && !is_pad) begin
                    err_next = 1'b1;
                end
                held_next = {held_eff[11:0], sx.sextet};
                pos_next  = pos_eff + 2'd1;
            end else begin
                // The fourth character must be padding in a short final group.
                if (owed_eff < LENGTH_WIDTH'(3) && !is_pad) begin
                    err_next = 1'b1;
                end
                grp_o.status = err_next;
                pos_next     = 2'd0;
                held_next    = 18'd0;
                owed_next    = owed_eff - LENGTH_WIDTH'(n);
                if (owed_next == '0) begin
                    err_next = 1'b0;
                end
            end
        end
    end

    assign advance_o  = in_valid_i && (!emit || out_can_load_i);
    assign grp_load_o = advance_o && emit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg  <= LENGTH_WIDTH'(LENGTH_RESET);
            owed_reg <= '0;
            held_reg <= 18'd0;
            pos_reg  <= 2'd0;
            err_reg  <= 1'b0;
        end else begin
            len_reg <= len_next;
            if (advance_o) begin
                owed_reg <= owed_next;
                held_reg <= held_next;
                pos_reg  <= pos_next;
                err_reg  <= err_next;
            end
        end
    end

endmodule

>>> sv/b64d_out_ser.sv
`timescale 1ns / 1ps
// ============================================================================
// b64d_out_ser
// Output serializer: holds one decoded group and sends its bytes one a cycle while m_tready is high.
// ============================================================================
module b64d_out_ser (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load_i,
    input  b64d_pkg::group_t  grp_i,
    output logic              can_load_o,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,
    output logic              m_tlast,
    output logic              m_tuser
);
    import b64d_pkg::*;

    logic [2:0][7:0] bytes_reg, bytes_next;
    logic [1:0]      cnt_reg, cnt_next;
    logic            fin_reg, fin_next;
    logic            status_reg, status_next;
    logic            pop;

    assign m_tvalid   = (cnt_reg != 2'd0);
    assign pop        = m_tvalid && m_tready;
    // A new group may land when the buffer is empty or its last byte leaves now.
    assign can_load_o = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && m_tready);

    always_comb begin
        bytes_next  = bytes_reg;
        cnt_next    = cnt_reg;
        fin_next    = fin_reg;
        status_next = status_reg;
        if (load_i) begin
            bytes_next  = grp_i.bytes;
            cnt_next    = grp_i.count;
            fin_next    = grp_i.fin;
            status_next = grp_i.status;
        end else if (pop) begin
            bytes_next = {8'd0, bytes_reg[2], bytes_reg[1]};
            cnt_next   = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
        bytes_reg  <= bytes_next;
        fin_reg    <= fin_next;
        status_reg <= status_next;
    end

    assign m_tdata = bytes_reg[0];
    assign m_tlast = fin_reg && (cnt_reg == 2'd1);
    assign m_tuser = m_tlast && status_reg;

endmodule

>>> test/b64d_tb_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// b64d_tb_pkg
// Scoreboard for the base64 stream decoder: predicts the decoded byte words
// from accepted character words and checks the words that leave the block.
// ============================================================================
package b64d_tb_pkg;

    // One decoded byte word as it leaves the block.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
        logic       status;
    } byte_word_t;

    class decode_scoreboard;
        logic [b64d_pkg::CFG_WIDTH-1:0]            frame_length;
        logic [17:0]                               group_sextets;
        logic [1:0]                                group_slot;
        logic [b64d_pkg::LENGTH_WIDTH_DEFAULT-1:0] bytes_left;
        logic                                      frame_error;
        byte_word_t                                expected_bytes[$];
        int                                        failures;

        function new();
            frame_length  = 16'(b64d_pkg::LENGTH_RESET);
            group_sextets = '0;
            group_slot    = '0;
            bytes_left    = '0;
            frame_error   = 1'b0;
            failures      = 0;
        endfunction

        function void set_length(logic [b64d_pkg::CFG_WIDTH-1:0] value);
            frame_length = value;
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction

        // Takes one accepted character word and queues the bytes it releases.
        // Returns 0 when the decoder ignores the word.
        function bit note_character(logic [7:0] symbol, logic frame_start);
            logic [5:0] value;
            logic       is_pad;
            logic [7:0] decoded[3];
            int         count;
            byte_word_t w;

            is_pad = (symbol == b64d_pkg::PAD_CHAR);
            if (frame_start) begin
                bytes_left    = frame_length;
                group_sextets = '0;
                group_slot    = '0;
                frame_error   = 1'b0;
            end
            if (bytes_left == 0) return 1'b0;

            value = '0;
            if (symbol >= "A" && symbol <= "Z") value = 6'(symbol - "A");
            else if (symbol >= "a" && symbol <= "z") value = 6'(symbol - "a" + 26);
            else if (symbol >= "0" && symbol <= "9") value = 6'(symbol - "0" + 52);
            else if (symbol == "+") value = 6'd62;
            else if (symbol == "/") value = 6'd63;
            else if (!is_pad) frame_error = 1'b1;

            if (group_slot != 2'd3) begin
                if (group_slot == 2'd2 && bytes_left == 1 && !is_pad) frame_error = 1'b1;
                group_sextets = {group_sextets[11:0], value};
                group_slot    = group_slot + 2'd1;
                return 1'b1;
            end

            group_slot = '0;
            if (bytes_left < 3 && !is_pad) frame_error = 1'b1;
            decoded[0] = {group_sextets[17:12], group_sextets[11:10]};
            decoded[1] = {group_sextets[9:6], group_sextets[5:2]};
            decoded[2] = {group_sextets[1:0], value};
            count = (bytes_left < 3) ? int'(bytes_left) : 3;
            for (int k = 0; k < count; k++) begin
                w.data_byte = decoded[k];
                w.last      = (k == count - 1) && (bytes_left == count);
                w.status    = w.last && frame_error;
                expected_bytes.push_back(w);
            end
            bytes_left    = bytes_left - 16'(count);
            group_sextets = '0;
            if (bytes_left == 0) frame_error = 1'b0;
            return 1'b1;
        endfunction

        function void check_result(logic [7:0] data_byte, logic last, logic status);
            byte_word_t w;
            if (expected_bytes.size() == 0) begin
                $error("unexpected word: data_byte %02h last %0b status %0b",
                       data_byte, last, status);
                failures++;
                return;
            end
            w = expected_bytes.pop_front();
            if (data_byte !== w.data_byte) begin
                $error("data_byte: expected %02h, got %02h", w.data_byte, data_byte);
                failures++;
            end
            if (last !== w.last) begin
                $error("last: expected %0b, got %0b", w.last, last);
                failures++;
            end
            if (status !== w.status) begin
                $error("status: expected %0b, got %0b", w.status, status);
                failures++;
            end
        endfunction
    endclass

endpackage

>>> test/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Self-checking bench for the base64 stream decoder: directed frames, then
// random frames under three idling patterns, checked word by word.
// ============================================================================
module tb_top;
    import b64d_tb_pkg::*;

    localparam int HALF_PERIOD      = 6;
    localparam int RESET_CYCLES     = 8;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES    = 8;
    localparam int MAX_FRAME_CHARS  = 48;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [15:0] cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        m_tuser;

    decode_scoreboard sb;

    // Idle percentages for each side; the main sequence changes them per mode.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    // Set by the main sequence to make the receiver hold off for a long stretch.
    bit long_hold_req = 1'b0;
    // Character words the decoder actually used; ignored words are not counted.
    int chars_used = 0;

    base64_stream_decoder_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // Hard limit on the run, with a wide margin over the slowest legal run.
    initial begin
        #2_000_000;
        $display("tb_top: errors");
        $finish;
    end

    // Receiver side: tready changes at the falling edge. A long hold is counted
    // here so that the sender keeps pushing while the output is blocked.
    initial begin : receiver_side
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (long_hold_req) begin
                hold_left     = LONG_HOLD_CYCLES;
                long_hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                m_tready  = 1'b0;
                hold_left = hold_left - 1;
            end else begin
                m_tready = ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Every byte word taken at a rising edge goes to the scoreboard.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_result(m_tdata, m_tlast, m_tuser);
        end
    end

    // Maps an index 0..63 to its character of the standard alphabet.
    function automatic logic [7:0] alphabet_char(int unsigned idx);
        if (idx < 26) return 8'("A" + idx);
        if (idx < 52) return 8'("a" + idx - 26);
        if (idx < 62) return 8'("0" + idx - 52);
        if (idx == 62) return 8'("+");
        return 8'("/");
    endfunction

    // Offers one character word, with random idle cycles in front of it, and
    // waits for the handshake. Called and returning at a falling edge.
    task automatic send_word(input logic [7:0] symbol, input logic frame_start);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = symbol;
        s_tuser  = frame_start;
        do @(posedge aclk); while (!s_tready);
        if (sb.note_character(symbol, frame_start)) chars_used++;
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    // Sends a short string; only its first character may carry frame start.
    task automatic send_text(input string txt, input logic frame_start);
        for (int k = 0; k < txt.len(); k++) begin
            send_word(8'(txt[k]), frame_start && k == 0);
        end
    endtask

    // Stops offering words until every expected byte has left the block, then
    // lets the pipeline run empty so that a register write cannot meet a
    // character still in flight.
    task automatic settle();
        s_tvalid = 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Writes decoded_length. The block must be idle when this is called.
    task automatic write_length(input logic [15:0] value);
        cfg_we    = 1'b1;
        cfg_wdata = value;
        sb.set_length(value);
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    // One random frame for the current length. Most frames are well formed
    // with random content; a few carry invalid characters, misplaced or
    // missing padding, or are cut short and left open for the next start.
    // Very long frames are only started, since they would never finish.
    task automatic send_frame(input int unsigned len);
        int unsigned full_chars, final_bytes, chars, k, slot, roll;
        logic [7:0]  c;
        bit          pad_slot;
        full_chars  = ((len + 2) / 3) * 4;
        final_bytes = len - 3 * ((len + 2) / 3 - 1);
        chars       = full_chars;
        if (chars > MAX_FRAME_CHARS) chars = $urandom_range(8, MAX_FRAME_CHARS);
        if ($urandom_range(99) < 8) chars = $urandom_range(1, chars);
        for (k = 0; k < chars; k++) begin
            slot     = k % 4;
            pad_slot = (k >= full_chars - 4) && (slot > final_bytes);
            c        = pad_slot ? b64d_pkg::PAD_CHAR : alphabet_char($urandom_range(63));
            roll     = $urandom_range(99);
            if (roll < 3) begin
                c = 8'($urandom_range(255));
            end else if (roll < 5) begin
                c = pad_slot ? alphabet_char($urandom_range(63)) : b64d_pkg::PAD_CHAR;
            end
            send_word(c, k == 0);
        end
        // Stray words between frames; the decoder drops them when idle.
        if ($urandom_range(99) < 10) begin
            repeat ($urandom_range(1, 2)) send_word(8'($urandom_range(255)), 1'b0);
        end
    endtask

    // Picks a frame length: mostly short frames, sometimes the extremes.
    function automatic int unsigned pick_length();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 8)  return 1;
        if (roll < 14) return 16'hffff;
        if (roll < 70) return $urandom_range(1, 12);
        if (roll < 90) return $urandom_range(13, 30);
        return $urandom_range(31, 16'hfffe);
    endfunction

    initial begin : main_sequence
        int unsigned len;
        int          target;
        sb = new();

        // Synchronous reset, held from the start and released at a falling
        // edge; it is never asserted again.
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // First idling pattern: the sender pauses often, the receiver more so.
        send_idle_pct = 34;
        recv_idle_pct = 61;

        // Directed part. A one-byte frame first: a stray word while idle, a
        // clean frame, then a frame with an invalid character and a third
        // character that should have been padding.
        write_length(16'd1);
        send_word(8'hff, 1'b0);
        send_text("TW==", 1'b1);
        send_text("A", 1'b1);
        send_word(8'h00, 1'b0);
        send_text("B=", 1'b0);
        // A frame abandoned after two characters by a new frame start.
        send_text("//", 1'b1);
        send_text("+/==", 1'b1);
        settle();
        // Zero length: the frame start leaves the decoder idle and the
        // characters are dropped.
        write_length(16'd0);
        send_text("AB", 1'b1);
        settle();
        // The longest frame, with padding in the middle of a group.
        write_length(16'hffff);
        send_text("z9+/", 1'b1);
        send_text("=Q=A", 1'b0);
        settle();

        // Random part in three idling modes, several register settings each.
        for (int mode = 0; mode < 3; mode++) begin
            if (mode == 1) begin
                send_idle_pct = 61;
                recv_idle_pct = 34;
            end else if (mode == 2) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            target = chars_used + 140;
            while (chars_used < target) begin
                settle();
                len = pick_length();
                write_length(16'(len));
                // In the mode without idling, block the output for a long
                // stretch once, so that the decoder fills and drops s_tready.
                if (mode == 2 && target - chars_used == 140) long_hold_req = 1'b1;
                repeat ($urandom_range(2, 5)) send_frame(len);
            end
        end

        // Let every expected byte arrive, plus a tail that would expose any
        // extra words from the block.
        settle();
        repeat (4 * SETTLE_CYCLES) @(negedge aclk);

        if (sb.failures == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
